// ----- rtl/ppa_pkg.sv -----
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types and constants of the pulse period averager.
// ----------------------------------------------------------------------------
`default_nettype none

package ppa_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int TIME_W        = 32;
	localparam int PERIOD_W      = 16;
	localparam int THR_W         = 10;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam int SLOT_COUNT_DEF = 10;
	localparam int MID_DEPTH      = 2;
	localparam int OUT_DEPTH      = 4;

	localparam logic [THR_W-1:0]    THRESHOLD_RST = THR_W'(0);
	localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(20);
	localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(1400);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL_THRESHOLD = 2'd0,
		REG_MIN_PERIOD      = 2'd1,
		REG_MAX_PERIOD      = 2'd2
	} ppa_reg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [TIME_W-1:0]      time_ms;
	} ppa_in_t;

	typedef struct packed {
		logic                level_high;
		logic [PERIOD_W-1:0] last_period;
		logic                period_accepted;
		logic [PERIOD_W-1:0] average_period;
		logic                ring_filled;
	} ppa_out_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic                level_high;
		logic [PERIOD_W-1:0] last_period;
		logic                accept;
		logic [PERIOD_W-1:0] span;
	} ppa_evt_t;

endpackage

`default_nettype wire

// ----- rtl/ppa_fifo.sv -----
// ----------------------------------------------------------------------------
// ppa_fifo
// Small register queue with occupancy count, used between the stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic                            full,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rdata,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IW-1:0]    wr_q;
	logic [IW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == CW'(0));
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == IW'(DEPTH-1)) ? '0 : wr_q + IW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == IW'(DEPTH-1)) ? '0 : rd_q + IW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ppa_front.sv -----
// ----------------------------------------------------------------------------
// ppa_front
// Level tracking, crossing detection and period measurement; holds the
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_front
	import ppa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire ppa_in_t               item,
	output ppa_evt_t                   evt,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic [THR_W-1:0]    thr_q;
	logic [PERIOD_W-1:0] min_q;
	logic [PERIOD_W-1:0] max_q;
	logic                level_q;
	logic                meas_q;
	logic [TIME_W-1:0]   start_q;
	logic [PERIOD_W-1:0] latest_q;

	logic [CMP_W-1:0]    smp_x;
	logic [CMP_W-1:0]    thr_x;
	logic                rise;
	logic                fall;
	logic                ends;
	logic                in_range;
	logic                lvl_next;
	logic [TIME_W-1:0]   span;
	logic [PERIOD_W-1:0] latest_next;

	assign cfg_ready = 1'b1;

	always_comb begin
		smp_x    = CMP_W'(item.sample);
		thr_x    = CMP_W'(thr_q);
		rise     = !level_q && (smp_x > thr_x);
		fall     = level_q && (smp_x < thr_x);
		span     = item.time_ms - start_q;
		ends     = rise && meas_q;
		in_range = (span > TIME_W'(min_q)) && (span <= TIME_W'(max_q));
		lvl_next = rise ? 1'b1 : (fall ? 1'b0 : level_q);
		if (ends) begin
			latest_next = (span[TIME_W-1:PERIOD_W] != '0) ? '1 : span[PERIOD_W-1:0];
		end else begin
			latest_next = latest_q;
		end
		evt.level_high  = lvl_next;
		evt.last_period = latest_next;
		evt.accept      = ends && in_range;
		evt.span        = span[PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RST;
			min_q    <= MIN_PERIOD_RST;
			max_q    <= MAX_PERIOD_RST;
			level_q  <= 1'b0;
			meas_q   <= 1'b0;
			start_q  <= '0;
			latest_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEVEL_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					REG_MIN_PERIOD:      min_q <= cfg_data[PERIOD_W-1:0];
					REG_MAX_PERIOD:      max_q <= cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (take) begin
				level_q  <= lvl_next;
				latest_q <= latest_next;
				if (rise) begin
					meas_q <= !meas_q;
					if (!meas_q) begin
						start_q <= item.time_ms;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ppa_back.sv -----
// ----------------------------------------------------------------------------
// ppa_back
// Period ring, running sum and average; two-stage pipeline into the
// result queue with credit-based flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_back
	import ppa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ppa_evt_t                     evt,
	input  wire logic                         evt_empty,
	output logic                              evt_pop,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                              out_push,
	output ppa_out_t                          out_data
);

	localparam int PW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SUM_W   = $clog2(SLOT_COUNT * 65535 + 1);
	localparam int LOG_N   = $clog2(SLOT_COUNT);
	localparam int SHIFT   = SUM_W + LOG_N;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int OCW     = $clog2(OUT_DEPTH+1);
	localparam logic [63:0] RECIP_C =
		((64'd1 << SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(SLOT_COUNT * 65535);

	logic [PERIOD_W-1:0] slot_mem [SLOT_COUNT];
	logic [PERIOD_W-1:0] rd_q;
	logic [PW-1:0]       ptr_q;
	logic                filled_q;
	logic [SUM_W-1:0]    sum_q;

	logic                v_s1;
	logic                level_s1;
	logic [PERIOD_W-1:0] last_s1;
	logic                acc_s1;
	logic                filled_s1;
	logic [SUM_W-1:0]    sum_s1;

	logic                v_s2;
	logic                level_s2;
	logic [PERIOD_W-1:0] last_s2;
	logic                acc_s2;
	logic                filled_s2;
	logic [PROD_W-1:0]   prod_s2;

	logic [OCW:0]        used;
	logic                do_acc;
	logic                wrap;
	logic [PERIOD_W-1:0] old_slot;
	logic [SUM_W-1:0]    sum_next;

	// results in flight plus those waiting must leave room for one more
	assign used    = (OCW+1)'(out_count) + (OCW+1)'(v_s1) + (OCW+1)'(v_s2);
	assign evt_pop = !evt_empty && (used < (OCW+1)'(OUT_DEPTH));
	assign do_acc  = evt_pop && evt.accept;
	assign wrap    = (ptr_q == PW'(SLOT_COUNT-1));
	// slots not yet written since reset read as zero
	assign old_slot = filled_q ? rd_q : '0;

	always_comb begin
		sum_next = sum_q;
		if (do_acc) begin
			sum_next = sum_q - SUM_W'(old_slot) + SUM_W'(evt.span);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			filled_q <= 1'b0;
			sum_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			v_s1 <= evt_pop;
			v_s2 <= v_s1;
			if (do_acc) begin
				ptr_q    <= wrap ? '0 : ptr_q + PW'(1);
				filled_q <= filled_q || wrap;
				sum_q    <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_acc) begin
			slot_mem[ptr_q] <= evt.span;
		end
		rd_q <= slot_mem[ptr_q];

		level_s1  <= evt.level_high;
		last_s1   <= evt.last_period;
		acc_s1    <= evt.accept;
		filled_s1 <= filled_q || (do_acc && wrap);
		sum_s1    <= sum_next;

		level_s2  <= level_s1;
		last_s2   <= last_s1;
		acc_s2    <= acc_s1;
		filled_s2 <= filled_s1;
		// exact floor division by the slot count via reciprocal
		prod_s2   <= PROD_W'(sum_s1) * PROD_W'(RECIP_C[RECIP_W-1:0]);
	end

	assign out_push = v_s2;

	always_comb begin
		out_data.level_high      = level_s2;
		out_data.last_period     = last_s2;
		out_data.period_accepted = acc_s2;
		out_data.average_period  = prod_s2[SHIFT +: PERIOD_W];
		out_data.ring_filled     = filled_s2;
	end

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PW'(SLOT_COUNT-1))
		else $error("ring pointer out of range");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("running sum above slot bound");

	// the slot read register must be refreshed between stored periods
	a_acc_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		do_acc |=> !do_acc)
		else $error("stored periods on adjacent cycles");

	a_filled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q |=> filled_q)
		else $error("ring filled flag dropped");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_count < OCW'(OUT_DEPTH)))
		else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- rtl/pulse_period_averager.sv -----
// ----------------------------------------------------------------------------
// pulse_period_averager
// Threshold-crossing pulse period meter with a ring average.
//
// Input queue side: drive sample_item and raise push; the transaction is
// taken at a clock edge with push high and full low. Result queue side: the
// oldest result sits on result while empty is low; pop takes it.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// threshold, minimum or maximum period register; cfg_ready is always high.
// Throughput: one transaction per cycle sustained while pop keeps up. Path: a
// taken input passes from the front to the middle queue, the ring/sum stage,
// the reciprocal multiply stage and the result queue before it is visible.
// When pop stalls, the back pipeline stops drawing from the two-entry middle
// queue once the four-entry result queue plus in-flight results is full;
// full then rises and input is held off. Nothing is dropped.
// Reset clears the level and measurement state, the ring pointer, running
// sum and fill flag, and loads the registers with 0, 20 and 1400. Ring
// slots are not swept; unwritten slots read as zero through the fill flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_period_averager
	import ppa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire ppa_in_t               sample_item,
	output logic                       empty,
	input  wire logic                  pop,
	output ppa_out_t                   result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int EVT_W = $bits(ppa_evt_t);
	localparam int RES_W = $bits(ppa_out_t);

	logic                         take;
	ppa_evt_t                     evt_in;
	ppa_evt_t                     evt_out;
	logic [EVT_W-1:0]             evt_rdata;
	logic                         mid_full;
	logic                         mid_empty;
	logic                         mid_pop;
	logic                         out_push;
	ppa_out_t                     out_data;
	logic [RES_W-1:0]             res_rdata;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	assign full      = mid_full;
	assign take      = push && !mid_full;
	assign evt_out   = ppa_evt_t'(evt_rdata);
	assign result    = ppa_out_t'(res_rdata);

	ppa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (sample_item),
		.evt       (evt_in),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ppa_fifo #(
		.WIDTH (EVT_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.wdata  (EVT_W'(evt_in)),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (evt_rdata),
		.empty  (mid_empty),
		.count  ()
	);

	ppa_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_out),
		.evt_empty (mid_empty),
		.evt_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	ppa_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (RES_W'(out_data)),
		.full   (),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty),
		.count  (out_count)
	);

endmodule

`default_nettype wire
